// ===== hdl/itoa_pkg.sv =====
// package: word types, character codes and digit lookup for the integer to ascii converter
`default_nettype none

package itoa_pkg;

  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned BCD_W     = 40;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned NDIG_W    = 4;

  localparam logic [CNT_W-1:0]  CONV_CYCLES_M1 = CNT_W'(VALUE_W - 1);
  localparam logic [NDIG_W-1:0] NUM_DEC_DIGITS = NDIG_W'(10);
  localparam logic [NDIG_W-1:0] NUM_HEX_DIGITS = NDIG_W'(8);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_UPPER = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_X     = 8'h78;

  localparam logic MODE_DEC = 1'b0;
  localparam logic MODE_HEX = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [VALUE_W-1:0] value;
  } itoa_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] text_char;
    logic              last;
  } itoa_out_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_UPPER + CHAR_W'(d - 4'd10);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/int_to_ascii_dec_hex.sv =====
// top level: converts a 32-bit word to decimal or hex ascii text, one character per output beat
//
//   channel | ports                          | payload
//   --------+--------------------------------+-----------------------------
//   input   | in_valid, in_ready, in_data    | mode, value
//   output  | out_valid, out_ready, out_data | text_char, last
//
// hex: after accept, "0x" then 8 hex digits, one character per cycle unless stalled
// decimal: after accept, shift-add-3 of all 32 value bits into the bcd register, then
//   leading-zero skip, then a minus if negative and the digits, one per cycle unless stalled
// one new word is taken only when the previous word's last character has been loaded
// into the output register; that register holds while out_ready is low
// rst_n is synchronous and active low; it clears the sequencer and output valid
`default_nettype none

module int_to_ascii_dec_hex (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire itoa_pkg::itoa_in_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output itoa_pkg::itoa_out_t     out_data
);
  import itoa_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SKIP = 4'b0100,
    ST_EMIT = 4'b1000
  } itoa_state_t;

  itoa_state_t         state_r, state_nxt;
  logic                mode_r, mode_nxt;
  logic [1:0]          pre_r, pre_nxt;
  logic [BCD_W-1:0]    digits_r, digits_nxt;
  logic [VALUE_W-1:0]  bin_r, bin_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [NDIG_W-1:0]   ndig_r, ndig_nxt;
  logic                out_valid_r, out_valid_nxt;
  itoa_out_t           out_data_r, out_data_nxt;

  logic [BCD_W-1:0]    adj;
  logic [VALUE_W-1:0]  mag;
  logic                slot_free;
  logic [3:0]          top_nib;

  // add 3 to every bcd digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < BCD_W / 4; i++) begin
      if (digits_r[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = digits_r[i*4 +: 4] + 4'd3;
      end else begin
        adj[i*4 +: 4] = digits_r[i*4 +: 4];
      end
    end
  end

  assign mag       = in_data.value[VALUE_W-1] ? (VALUE_W'(0) - in_data.value) : in_data.value;
  assign slot_free = !out_valid_r || out_ready;
  assign top_nib   = digits_r[BCD_W-1 -: 4];
  assign in_ready  = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    pre_nxt       = pre_r;
    digits_nxt    = digits_r;
    bin_nxt       = bin_r;
    cnt_nxt       = cnt_r;
    ndig_nxt      = ndig_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          mode_nxt = in_data.mode;
          if (in_data.mode == MODE_HEX) begin
            pre_nxt    = 2'd2;
            digits_nxt = {in_data.value, 8'h00};
            ndig_nxt   = NUM_HEX_DIGITS;
            state_nxt  = ST_EMIT;
          end else begin
            pre_nxt    = {1'b0, in_data.value[VALUE_W-1]};
            digits_nxt = '0;
            bin_nxt    = mag;
            cnt_nxt    = CONV_CYCLES_M1;
            state_nxt  = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        digits_nxt = {adj[BCD_W-2:0], bin_r[VALUE_W-1]};
        bin_nxt    = {bin_r[VALUE_W-2:0], 1'b0};
        if (cnt_r == '0) begin
          ndig_nxt  = NUM_DEC_DIGITS;
          state_nxt = ST_SKIP;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      ST_SKIP: begin
        if (top_nib == 4'd0 && ndig_r > NDIG_W'(1)) begin
          digits_nxt = {digits_r[BCD_W-5:0], 4'h0};
          ndig_nxt   = ndig_r - NDIG_W'(1);
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (pre_r != 2'd0) begin
            if (mode_r == MODE_DEC) begin
              out_data_nxt.text_char = CHAR_MINUS;
            end else if (pre_r == 2'd2) begin
              out_data_nxt.text_char = CHAR_ZERO;
            end else begin
              out_data_nxt.text_char = CHAR_X;
            end
            out_data_nxt.last = 1'b0;
            pre_nxt           = pre_r - 2'd1;
          end else begin
            out_data_nxt.text_char = digit_char(top_nib);
            out_data_nxt.last      = (ndig_r == NDIG_W'(1));
            digits_nxt             = {digits_r[BCD_W-5:0], 4'h0};
            ndig_nxt               = ndig_r - NDIG_W'(1);
            if (ndig_r == NDIG_W'(1)) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pre_r       <= 2'd0;
      cnt_r       <= '0;
      ndig_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pre_r       <= pre_nxt;
      cnt_r       <= cnt_nxt;
      ndig_r      <= ndig_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    digits_r   <= digits_nxt;
    bin_r      <= bin_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_emit_has_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (ndig_r != '0))
    else $error("emit state with no digits left");

  a_hex_no_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SKIP || state_r == ST_CONV) |-> (mode_r == MODE_DEC))
    else $error("hex word in decimal conversion path");

  a_hex_digit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && mode_r == MODE_HEX) |-> (ndig_r <= NUM_HEX_DIGITS))
    else $error("hex digit count too large");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != ST_IDLE))
    else $error("sequencer idle after accepting a word");

  a_dec_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE && mode_r == MODE_DEC) |-> (pre_r <= 2'd1))
    else $error("decimal word with more than one prefix character");
`endif

endmodule

`default_nettype wire
